/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/lwfs_pkg.sv */
// ---------------------------------------------------------------------------
// lwfs_pkg
// Types, widths and opcodes shared by the window fill streamer modules.
// ---------------------------------------------------------------------------
package lwfs_pkg;

    localparam int COORD_W     = 16;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 4;
    localparam int IN_DATA_W   = 80;
    localparam int MAX_SIDE_DEF = 320;

    // Controller opcodes
    localparam logic [BYTE_W-1:0] OP_COLUMN_SET   = 8'h2A;
    localparam logic [BYTE_W-1:0] OP_ROW_SET      = 8'h2B;
    localparam logic [BYTE_W-1:0] OP_MEMORY_WRITE = 8'h2C;

    // Input beat kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCREEN_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCREEN_H = 1'b1;

    localparam logic [CFG_W-1:0] SCREEN_W_RESET = 9'd240;
    localparam logic [CFG_W-1:0] SCREEN_H_RESET = 9'd320;

    // Largest side the registers can actually hold after saturation
    function automatic int side_cap(input int max_side);
        int full;
        full = (1 << CFG_W) - 1;
        return (max_side < full) ? max_side : full;
    endfunction

    // Byte position within a transfer
    typedef enum logic [POS_W-1:0] {
        POS_COL_OP,
        POS_COL_SH,
        POS_COL_SL,
        POS_COL_EH,
        POS_COL_EL,
        POS_ROW_OP,
        POS_ROW_SH,
        POS_ROW_SL,
        POS_ROW_EH,
        POS_ROW_EL,
        POS_MEM_OP,
        POS_PIXELS
    } hdr_pos_t;

    // Clipped address window for one start beat
    typedef struct packed {
        logic               drop;
        logic [COORD_W-1:0] col_start;
        logic [COORD_W-1:0] col_end;
        logic [COORD_W-1:0] row_start;
        logic [COORD_W-1:0] row_end;
        logic [CFG_W-1:0]   width;
        logic [CFG_W-1:0]   height;
    } window_t;

    // Sequencer status
    typedef struct packed {
        logic     busy;
        logic     mul_pend;
        hdr_pos_t byte_pos;
    } seq_status_t;

endpackage

/* hw/rtl/lwfs_cfg_regs.sv */
// ---------------------------------------------------------------------------
// lwfs_cfg_regs
// Screen size registers with saturation to the largest supported side.
// ---------------------------------------------------------------------------
module lwfs_cfg_regs #(
    parameter int MAX_SIDE = lwfs_pkg::MAX_SIDE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lwfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lwfs_pkg::CFG_W-1:0]     cfg_wr_data,
    output logic [lwfs_pkg::CFG_W-1:0]     screen_w,
    output logic [lwfs_pkg::CFG_W-1:0]     screen_h
);
    import lwfs_pkg::*;

    localparam int SIDE_CAP = side_cap(MAX_SIDE);

    logic [CFG_W-1:0] wr_sat;
    logic [CFG_W-1:0] screen_w_reg;
    logic [CFG_W-1:0] screen_h_reg;

    // Clamp oversized writes
    always_comb begin
        if (32'(cfg_wr_data) > SIDE_CAP) begin
            wr_sat = CFG_W'(SIDE_CAP);
        end else begin
            wr_sat = cfg_wr_data;
        end
    end

    // Hold the screen size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_w_reg <= SCREEN_W_RESET;
            screen_h_reg <= SCREEN_H_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IDX_SCREEN_W: screen_w_reg <= wr_sat;
                CFG_IDX_SCREEN_H: screen_h_reg <= wr_sat;
                default: ;
            endcase
        end
    end

    assign screen_w = screen_w_reg;
    assign screen_h = screen_h_reg;

endmodule

/* hw/rtl/lwfs_window_clip.sv */
// ---------------------------------------------------------------------------
// lwfs_window_clip
// Checks a rectangle against the screen and clips its extent to the edge.
// ---------------------------------------------------------------------------
module lwfs_window_clip (
    input  logic [lwfs_pkg::CFG_W-1:0]   screen_w,
    input  logic [lwfs_pkg::CFG_W-1:0]   screen_h,
    input  logic [lwfs_pkg::COORD_W-1:0] rect_x,
    input  logic [lwfs_pkg::COORD_W-1:0] rect_y,
    input  logic [lwfs_pkg::COORD_W-1:0] rect_w,
    input  logic [lwfs_pkg::COORD_W-1:0] rect_h,
    output lwfs_pkg::window_t            win
);
    import lwfs_pkg::*;

    logic [COORD_W:0]   x_far;
    logic [COORD_W:0]   y_far;
    logic [CFG_W-1:0]   w_clip;
    logic [CFG_W-1:0]   h_clip;

    // Far edges, one bit wider so they cannot wrap
    assign x_far = {1'b0, rect_x} + {1'b0, rect_w} - (COORD_W+1)'(1);
    assign y_far = {1'b0, rect_y} + {1'b0, rect_h} - (COORD_W+1)'(1);

    // Clip a non-zero extent that runs past the edge
    always_comb begin
        if (rect_w != '0 && x_far >= (COORD_W+1)'(screen_w)) begin
            w_clip = screen_w - rect_x[CFG_W-1:0];
        end else begin
            w_clip = rect_w[CFG_W-1:0];
        end
        if (rect_h != '0 && y_far >= (COORD_W+1)'(screen_h)) begin
            h_clip = screen_h - rect_y[CFG_W-1:0];
        end else begin
            h_clip = rect_h[CFG_W-1:0];
        end
    end

    // Assemble the window; a zero extent gives end = start - 1
    always_comb begin
        win.drop      = (rect_x >= COORD_W'(screen_w)) || (rect_y >= COORD_W'(screen_h));
        win.col_start = rect_x;
        win.col_end   = rect_x + COORD_W'(w_clip) - COORD_W'(1);
        win.row_start = rect_y;
        win.row_end   = rect_y + COORD_W'(h_clip) - COORD_W'(1);
        win.width     = w_clip;
        win.height    = h_clip;
    end

endmodule

/* hw/rtl/lwfs_byte_seq.sv */
// ---------------------------------------------------------------------------
// lwfs_byte_seq
// Transfer state: latches a window on start and yields one byte per tick.
// ---------------------------------------------------------------------------
module lwfs_byte_seq #(
    parameter int PIX_W = 17
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          cmd,
    input  lwfs_pkg::window_t             win,
    input  logic [lwfs_pkg::COORD_W-1:0]  color,
    output logic                          res_valid,
    output logic [lwfs_pkg::BYTE_W-1:0]   res_byte,
    output logic                          res_is_data,
    output logic                          res_last,
    output lwfs_pkg::seq_status_t         status
);
    import lwfs_pkg::*;

    // Control state
    logic     busy_reg, busy_next;
    logic     low_half_reg, low_half_next;
    logic     mul_pend_reg, mul_pend_next;
    hdr_pos_t pos_reg, pos_next;

    // Payload state
    logic [COORD_W-1:0] col_start_reg, col_start_next;
    logic [COORD_W-1:0] col_end_reg, col_end_next;
    logic [COORD_W-1:0] row_start_reg, row_start_next;
    logic [COORD_W-1:0] row_end_reg, row_end_next;
    logic [COORD_W-1:0] color_reg, color_next;
    logic [CFG_W-1:0]   width_reg, width_next;
    logic [CFG_W-1:0]   height_reg, height_next;
    logic [PIX_W-1:0]   pixels_reg, pixels_next;

    logic [2*CFG_W-1:0] pix_product;
    logic [PIX_W-1:0]   pix_dec;
    logic               tick;

    assign tick        = step && (cmd == CMD_TICK) && busy_reg;
    assign pix_product = (2*CFG_W)'(width_reg) * (2*CFG_W)'(height_reg);
    assign pix_dec     = (pixels_reg != '0) ? pixels_reg - PIX_W'(1) : pixels_reg;

    // Output byte for the current position
    always_comb begin
        res_valid   = tick;
        res_is_data = 1'b1;
        res_last    = 1'b0;
        case (pos_reg)
            POS_COL_OP: begin
                res_byte    = OP_COLUMN_SET;
                res_is_data = 1'b0;
            end
            POS_COL_SH: res_byte = col_start_reg[15:8];
            POS_COL_SL: res_byte = col_start_reg[7:0];
            POS_COL_EH: res_byte = col_end_reg[15:8];
            POS_COL_EL: res_byte = col_end_reg[7:0];
            POS_ROW_OP: begin
                res_byte    = OP_ROW_SET;
                res_is_data = 1'b0;
            end
            POS_ROW_SH: res_byte = row_start_reg[15:8];
            POS_ROW_SL: res_byte = row_start_reg[7:0];
            POS_ROW_EH: res_byte = row_end_reg[15:8];
            POS_ROW_EL: res_byte = row_end_reg[7:0];
            POS_MEM_OP: begin
                res_byte    = OP_MEMORY_WRITE;
                res_is_data = 1'b0;
                res_last    = (pixels_reg == '0);
            end
            POS_PIXELS: begin
                res_byte = low_half_reg ? color_reg[7:0] : color_reg[15:8];
                res_last = low_half_reg && (pix_dec == '0);
            end
            default: begin
                res_byte    = OP_MEMORY_WRITE;
                res_is_data = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        busy_next      = busy_reg;
        low_half_next  = low_half_reg;
        mul_pend_next  = 1'b0;
        pos_next       = pos_reg;
        col_start_next = col_start_reg;
        col_end_next   = col_end_reg;
        row_start_next = row_start_reg;
        row_end_next   = row_end_reg;
        color_next     = color_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        pixels_next    = pixels_reg;

        // Pixel count lands in the cycle after the start, well before it is read
        if (mul_pend_reg) begin
            pixels_next = PIX_W'(pix_product);
        end

        if (step && cmd == CMD_START) begin
            // Latch a new window; drop starts while busy or off screen
            if (!busy_reg && !win.drop) begin
                busy_next      = 1'b1;
                low_half_next  = 1'b0;
                mul_pend_next  = 1'b1;
                pos_next       = POS_COL_OP;
                col_start_next = win.col_start;
                col_end_next   = win.col_end;
                row_start_next = win.row_start;
                row_end_next   = win.row_end;
                color_next     = color;
                width_next     = win.width;
                height_next    = win.height;
            end
        end else if (tick) begin
            if (res_last) begin
                busy_next     = 1'b0;
                low_half_next = 1'b0;
                pos_next      = POS_COL_OP;
                pixels_next   = pix_dec;
            end else if (pos_reg == POS_PIXELS) begin
                low_half_next = !low_half_reg;
                if (low_half_reg) begin
                    pixels_next = pix_dec;
                end
            end else begin
                pos_next = hdr_pos_t'(pos_reg + POS_W'(1));
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            low_half_reg <= 1'b0;
            mul_pend_reg <= 1'b0;
            pos_reg      <= POS_COL_OP;
        end else begin
            busy_reg     <= busy_next;
            low_half_reg <= low_half_next;
            mul_pend_reg <= mul_pend_next;
            pos_reg      <= pos_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        col_start_reg <= col_start_next;
        col_end_reg   <= col_end_next;
        row_start_reg <= row_start_next;
        row_end_reg   <= row_end_next;
        color_reg     <= color_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        pixels_reg    <= pixels_next;
    end

    assign status.busy     = busy_reg;
    assign status.mul_pend = mul_pend_reg;
    assign status.byte_pos = pos_reg;

endmodule

/* hw/rtl/lcd_window_fill_streamer.sv */
// ---------------------------------------------------------------------------
// lcd_window_fill_streamer
// Address window rectangle fill: streams header and pixel bytes per tick.
// ---------------------------------------------------------------------------
// Path: a tick beat passes the input register, then the result register, before
//   its byte shows on m_tdata. Throughput: one beat per cycle unless m_tready
//   holds the result register, set by the single pass through the byte
//   sequencer; the pixel count multiply sits in the cycle after a start.
// Reset: aresetn synchronous, active low; the block comes up idle with a
//   240 x 320 screen and empty input and result registers.
`include "assert_macros.svh"

module lcd_window_fill_streamer #(
    parameter int MAX_SIDE = lwfs_pkg::MAX_SIDE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [lwfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lwfs_pkg::CFG_W-1:0]     cfg_wr_data,
    // Command and tick beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rect_x [15:0], rect_y [31:16], rect_w [47:32], rect_h [63:48], color [79:64]
    input  logic [lwfs_pkg::IN_DATA_W-1:0] s_tdata,
    // cmd [0]
    input  logic                           s_tuser,
    // Byte beats to the display controller
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte [7:0]
    output logic [lwfs_pkg::BYTE_W-1:0]    m_tdata,
    // is_data [0]
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import lwfs_pkg::*;

    localparam int SIDE_CAP = side_cap(MAX_SIDE);
    localparam int PIX_W    = $clog2(SIDE_CAP * SIDE_CAP + 1);

    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic                 advance;

    logic [CFG_W-1:0]     screen_w;
    logic [CFG_W-1:0]     screen_h;
    window_t              win;
    seq_status_t          seq_stat;

    logic                 res_valid;
    logic [BYTE_W-1:0]    res_byte;
    logic                 res_is_data;
    logic                 res_last;

    logic                 m_valid_reg;
    logic [BYTE_W-1:0]    m_byte_reg;
    logic                 m_is_data_reg;
    logic                 m_last_reg;

    // Advance the held beat when the result register has room
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    lwfs_cfg_regs #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .screen_w    (screen_w),
        .screen_h    (screen_h)
    );

    lwfs_window_clip u_clip (
        .screen_w (screen_w),
        .screen_h (screen_h),
        .rect_x   (in_data_reg[15:0]),
        .rect_y   (in_data_reg[31:16]),
        .rect_w   (in_data_reg[47:32]),
        .rect_h   (in_data_reg[63:48]),
        .win      (win)
    );

    lwfs_byte_seq #(
        .PIX_W (PIX_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .cmd         (in_cmd_reg),
        .win         (win),
        .color       (in_data_reg[79:64]),
        .res_valid   (res_valid),
        .res_byte    (res_byte),
        .res_is_data (res_is_data),
        .res_last    (res_last),
        .status      (seq_stat)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_byte_reg    <= res_byte;
            m_is_data_reg <= res_is_data;
            m_last_reg    <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_is_data_reg;
    assign m_tlast  = m_last_reg;

    // Checks on the sequencer
    `ASSERT_NEXT(a_last_ends_fill, aclk, aresetn, advance && res_valid && res_last, !seq_stat.busy)
    `ASSERT_IMPLIES(a_mul_after_start, aclk, aresetn, seq_stat.mul_pend, seq_stat.busy && seq_stat.byte_pos == POS_COL_OP)
    `ASSERT_IMPLIES(a_idle_at_header, aclk, aresetn, !seq_stat.busy, seq_stat.byte_pos == POS_COL_OP)

endmodule
